// ===== rtl/gisr_pkg.sv =====
// Shared types, constants and helpers for the GUE inner source rewriter.
`default_nettype none
package gisr_pkg;

	localparam int unsigned POS_W = 7;
	localparam logic [POS_W-1:0] POS_MAX = 7'd127;

	// Header check positions
	localparam logic [POS_W-1:0] POS_ETYPE_HI   = 7'd12;
	localparam logic [POS_W-1:0] POS_ETYPE_LO   = 7'd13;
	localparam logic [POS_W-1:0] POS_OUTER_NH   = 7'd20;
	localparam logic [POS_W-1:0] POS_OSRC_FIRST = 7'd22;
	localparam logic [POS_W-1:0] POS_OSRC_LAST  = 7'd37;
	localparam logic [POS_W-1:0] POS_UDP_DP_HI  = 7'd56;
	localparam logic [POS_W-1:0] POS_UDP_DP_LO  = 7'd57;
	localparam logic [POS_W-1:0] POS_INNER_VER  = 7'd62;
	localparam logic [POS_W-1:0] POS_INNER_NH   = 7'd68;
	localparam logic [POS_W-1:0] POS_ISRC_FIRST = 7'd70;
	localparam logic [POS_W-1:0] POS_ISRC_LAST  = 7'd85;
	localparam logic [POS_W-1:0] POS_TCP_CSUM_LO = 7'd119;
	localparam logic [POS_W-1:0] POS_MIN_FRAME  = 7'd13;

	localparam logic [7:0] ETYPE_IPV6_HI = 8'h86;
	localparam logic [7:0] ETYPE_IPV6_LO = 8'hDD;
	localparam logic [7:0] PROTO_UDP     = 8'd17;
	localparam logic [7:0] PROTO_TCP     = 8'd6;

	localparam logic [15:0] GUE_PORT_RST   = 16'd9886;
	localparam logic [7:0]  IPV6_MASK_RST  = 8'd48;

	// Configuration register indexes
	localparam logic CFG_GUE_PORT  = 1'b0;
	localparam logic CFG_IPV6_MASK = 1'b1;

	localparam int unsigned SRC_DEPTH = 16;
	localparam int unsigned SRC_AW    = $clog2(SRC_DEPTH);

	localparam int unsigned OQ_DEPTH = 4;
	localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       verdict;
	} res_t;

	// Up to two results per processed byte; en1 only with en0
	typedef struct packed {
		logic en0;
		logic en1;
		res_t r0;
		res_t r1;
	} push_t;

	// Ones'-complement 16-bit add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage
`default_nettype wire

// ===== rtl/gisr_chan_if.sv =====
// Valid/ready channel interfaces for frame bytes in and result bytes out.
`default_nettype none
interface gisr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;

	modport source(output valid, output data_byte, output frame_end, input ready);
	modport sink(input valid, input data_byte, input frame_end, output ready);
endinterface

interface gisr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic       verdict;

	modport source(output valid, output out_byte, output out_last, output verdict,
		input ready);
	modport sink(input valid, input out_byte, input out_last, input verdict,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/gisr_core.sv =====
// Per-byte header checks, address rewrite and incremental checksum update.
`default_nettype none
module gisr_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      fire,
	input  wire logic [7:0]                data_byte,
	input  wire logic                      frame_end,
	input  wire logic [15:0]               gue_port,
	input  wire logic [7:0]                inner_ipv6_mask,
	output gisr_pkg::push_t                push
);

	logic [gisr_pkg::POS_W-1:0] pos_q;
	logic                       match_q;
	logic [15:0]                delta_q;
	logic [7:0]                 pend_q;
	logic [7:0]                 held_q;
	logic                       held_vld_q;
	logic [7:0]                 src_hi_q;
	logic [7:0]                 src_q [gisr_pkg::SRC_DEPTH];

	logic                       fail;
	logic                       match_now;
	logic [gisr_pkg::POS_W-1:0] wr_off;
	logic [gisr_pkg::POS_W-1:0] rd_off;
	logic                       src_we;
	logic                       rewrite;
	logic [7:0]                 src_rd;
	logic [15:0]                m_old;
	logic [15:0]                m_new;
	logic [15:0]                delta_nxt;
	logic                       fix_csum;
	logic [15:0]                new_csum;
	logic [7:0]                 ob;
	logic [7:0]                 prev;
	gisr_pkg::res_t             r_prev;
	gisr_pkg::res_t             r_last;

	always_comb begin
		fail = (pos_q == gisr_pkg::POS_ETYPE_HI && data_byte != gisr_pkg::ETYPE_IPV6_HI)
			|| (pos_q == gisr_pkg::POS_ETYPE_LO && data_byte != gisr_pkg::ETYPE_IPV6_LO)
			|| (pos_q == gisr_pkg::POS_OUTER_NH && data_byte != gisr_pkg::PROTO_UDP)
			|| (pos_q == gisr_pkg::POS_UDP_DP_HI && data_byte != gue_port[15:8])
			|| (pos_q == gisr_pkg::POS_UDP_DP_LO && data_byte != gue_port[7:0])
			|| (pos_q == gisr_pkg::POS_INNER_VER && (data_byte & inner_ipv6_mask) == 8'd0)
			|| (pos_q == gisr_pkg::POS_INNER_NH && data_byte != gisr_pkg::PROTO_TCP);
		match_now = match_q && !fail;

		wr_off  = pos_q - gisr_pkg::POS_OSRC_FIRST;
		rd_off  = pos_q - gisr_pkg::POS_ISRC_FIRST;
		src_we  = pos_q >= gisr_pkg::POS_OSRC_FIRST && pos_q <= gisr_pkg::POS_OSRC_LAST;
		rewrite = match_now && pos_q >= gisr_pkg::POS_ISRC_FIRST
			&& pos_q <= gisr_pkg::POS_ISRC_LAST;
		src_rd  = src_q[rd_off[gisr_pkg::SRC_AW-1:0]];

		// Odd byte closes a 16-bit word: fold ~old + new into the delta
		m_old     = {pend_q, data_byte};
		m_new     = {src_hi_q, src_rd};
		delta_nxt = gisr_pkg::oc_add(delta_q, gisr_pkg::oc_add(~m_old, m_new));

		fix_csum = pos_q == gisr_pkg::POS_TCP_CSUM_LO && match_now && held_vld_q;
		new_csum = ~gisr_pkg::oc_add(~{held_q, data_byte}, delta_q);

		ob   = rewrite ? src_rd : data_byte;
		prev = held_q;
		if (fix_csum) begin
			prev = new_csum[15:8];
			ob   = new_csum[7:0];
		end

		r_prev = '{out_byte: prev, out_last: 1'b0, verdict: 1'b0};
		r_last = '{out_byte: ob, out_last: 1'b1,
			verdict: (pos_q < gisr_pkg::POS_MIN_FRAME)};

		push.en0 = fire && (held_vld_q || frame_end);
		push.en1 = fire && held_vld_q && frame_end;
		push.r0  = held_vld_q ? r_prev : r_last;
		push.r1  = r_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			match_q    <= 1'b1;
			delta_q    <= '0;
			pend_q     <= '0;
			held_q     <= '0;
			held_vld_q <= 1'b0;
		end else if (fire) begin
			if (frame_end) begin
				pos_q      <= '0;
				match_q    <= 1'b1;
				delta_q    <= '0;
				pend_q     <= '0;
				held_q     <= '0;
				held_vld_q <= 1'b0;
			end else begin
				held_q     <= ob;
				held_vld_q <= 1'b1;
				match_q    <= match_now;
				if (pos_q != gisr_pkg::POS_MAX) begin
					pos_q <= pos_q + 1'b1;
				end
				if (rewrite && !pos_q[0]) begin
					pend_q <= data_byte;
				end
				if (rewrite && pos_q[0]) begin
					delta_q <= delta_nxt;
				end
			end
		end
	end

	// Outer source store and the new high byte of the word being rewritten
	always_ff @(posedge clk) begin
		if (fire && src_we) begin
			src_q[wr_off[gisr_pkg::SRC_AW-1:0]] <= data_byte;
		end
		if (fire && rewrite && !pos_q[0]) begin
			src_hi_q <= src_rd;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/gisr_outq.sv =====
// Result queue: takes up to two results a cycle, hands out one.
`default_nettype none
module gisr_outq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire gisr_pkg::push_t push,
	output logic                room,
	output logic                valid,
	input  wire logic           ready,
	output gisr_pkg::res_t      head
);

	gisr_pkg::res_t             ent_q [gisr_pkg::OQ_DEPTH];
	logic [gisr_pkg::OQ_AW-1:0] wr_q;
	logic [gisr_pkg::OQ_AW-1:0] rd_q;
	logic [gisr_pkg::OQ_AW:0]   cnt_q;
	logic                       pop;
	logic [gisr_pkg::OQ_AW:0]   n_push;
	logic [gisr_pkg::OQ_AW-1:0] wr_nxt1;

	always_comb begin
		valid   = cnt_q != '0;
		head    = ent_q[rd_q];
		pop     = valid && ready;
		// Two free slots needed so a closing byte can push both results
		room    = cnt_q <= (gisr_pkg::OQ_AW+1)'(gisr_pkg::OQ_DEPTH - 2);
		n_push  = (gisr_pkg::OQ_AW+1)'(push.en0) + (gisr_pkg::OQ_AW+1)'(push.en1);
		wr_nxt1 = wr_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_push[gisr_pkg::OQ_AW-1:0];
			cnt_q <= cnt_q + n_push - (gisr_pkg::OQ_AW+1)'(pop);
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.en0) begin
			ent_q[wr_q] <= push.r0;
		end
		if (push.en1) begin
			ent_q[wr_nxt1] <= push.r1;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/gue_inner_source_rewriter_unit.sv =====
// Top level of the GUE inner source rewriter.
//
// Usage: frame bytes enter on in_ch (data_byte, frame_end on the final byte)
// and leave on out_ch (out_byte, out_last, verdict). Each output byte is the
// input byte from one transfer earlier, so a byte leaves once the next byte
// of its frame has been taken; the closing byte releases both the held byte
// and itself. For GUE-over-IPv6 frames carrying inner IPv6/TCP, the inner
// source address is replaced by the outer one and the TCP checksum patched
// incrementally. verdict is 1 on the final byte of a frame under 14 bytes.
// Throughput: one input byte per clock while out_ch keeps taking results;
// a closing byte pushes two results, absorbed by the four-entry result queue.
// An accepted byte is captured in the input register and processed once
// the result queue has two free slots; its results are written to the
// result queue, whose head drives out_ch. in_ch.ready drops only when
// the input register is full and the queue lacks two free slots, i.e.
// when out_ch stalls.
// Reset: arst_n clears the input register, queue and frame state; gue_port
// returns to 9886 and the inner IPv6 mask to 48. The outer source store is
// not cleared. Configuration writes land on cfg_we at the next clock edge.
`default_nettype none
module gue_inner_source_rewriter_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	gisr_in_if.sink    in_ch,
	gisr_out_if.source out_ch,
	input  wire logic  cfg_we,
	input  wire logic  cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	logic [15:0]     gue_port_q;
	logic [7:0]      ipv6_mask_q;

	logic            vld_s1;
	logic [7:0]      byte_s1;
	logic            end_s1;

	logic            room;
	logic            fire;
	gisr_pkg::push_t push;
	gisr_pkg::res_t  head;

	// Configuration registers; unknown indexes cannot occur with one index bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gue_port_q  <= gisr_pkg::GUE_PORT_RST;
			ipv6_mask_q <= gisr_pkg::IPV6_MASK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gisr_pkg::CFG_GUE_PORT:  gue_port_q  <= cfg_wdata;
				gisr_pkg::CFG_IPV6_MASK: ipv6_mask_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Process the held byte when the queue can take both possible results
	assign fire        = vld_s1 && room;
	assign in_ch.ready = !vld_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			vld_s1 <= in_ch.valid;
		end
	end

	// Input payload register: hold while stalled
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.data_byte;
			end_s1  <= in_ch.frame_end;
		end
	end

	gisr_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.data_byte       (byte_s1),
		.frame_end       (end_s1),
		.gue_port        (gue_port_q),
		.inner_ipv6_mask (ipv6_mask_q),
		.push            (push)
	);

	gisr_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.valid  (out_ch.valid),
		.ready  (out_ch.ready),
		.head   (head)
	);

	assign out_ch.out_byte = head.out_byte;
	assign out_ch.out_last = head.out_last;
	assign out_ch.verdict  = head.verdict;

endmodule
`default_nettype wire

// ===== rtl/gisr_checker.sv =====
// Port-level checks for the GUE inner source rewriter, bound to the top level.
`default_nettype none
module gisr_port_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       out_last,
	input wire logic       verdict
);

	// Reset empties the result queue
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid while in reset");

	// Drop verdict only travels on the closing byte
	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict |-> out_last)
		else $error("verdict set on a non-final byte");

	// A stalled result keeps its payload
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(out_last) && $stable(verdict))
		else $error("stalled result changed");

endmodule

bind gue_inner_source_rewriter_unit gisr_port_checker u_gisr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.out_last  (out_ch.out_last),
	.verdict   (out_ch.verdict)
);
`default_nettype wire
